// ===== rtl/pkb_pkg.sv =====
// ----------------------------------------------------------------------------
// PackBits compressor package
// Shared constants, phase codes and transaction types of the compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package pkb_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned CMD_DEPTH_DEF = 4;

  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [1:0] PH_INITIAL = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_RUN     = 2'd2;
  localparam logic [1:0] PH_LITRUN  = 2'd3;

  localparam logic [7:0] CHUNK_MAX   = 8'd128;
  localparam logic [6:0] LIT_LAST    = 7'd127;
  localparam logic [6:0] MERGE_LIMIT = 7'd125;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } pkb_in_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        stream_done;
    logic [15:0] output_length;
    logic        last_of_item;
  } pkb_out_t;

  typedef struct packed {
    logic       has_chunk;
    logic       is_end;
    logic [7:0] run_len;
    logic [7:0] run_byte;
  } pkb_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/pkb_front.sv =====
// ----------------------------------------------------------------------------
// PackBits run collector
// Gathers equal input bytes into a pending run and issues pack commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pkb_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_accept_i,
  input  wire pkb_pkg::pkb_in_t  in_item_i,
  output logic                   cmd_push_o,
  output pkb_pkg::pkb_cmd_t      cmd_o
);
  import pkb_pkg::*;

  logic [7:0] byte_q, byte_d;
  logic [7:0] cnt_q, cnt_d;

  always_comb begin
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    byte_d     = byte_q;
    cnt_d      = cnt_q;
    if (in_accept_i) begin
      if (in_item_i.action == ACT_END) begin
        cmd_push_o       = 1'b1;
        cmd_o.has_chunk  = (cnt_q != 8'd0);
        cmd_o.is_end     = 1'b1;
        cmd_o.run_len    = cnt_q;
        cmd_o.run_byte   = byte_q;
        cnt_d            = 8'd0;
        byte_d           = 8'd0;
      end else if (cnt_q == 8'd0) begin
        byte_d = in_item_i.data_byte;
        cnt_d  = 8'd1;
      end else if (in_item_i.data_byte == byte_q) begin
        if (cnt_q < CHUNK_MAX) begin
          cnt_d = cnt_q + 8'd1;
        end else begin
          cmd_push_o      = 1'b1;
          cmd_o.has_chunk = 1'b1;
          cmd_o.run_len   = CHUNK_MAX;
          cmd_o.run_byte  = byte_q;
          cnt_d           = 8'd1;
        end
      end else begin
        cmd_push_o      = 1'b1;
        cmd_o.has_chunk = 1'b1;
        cmd_o.run_len   = cnt_q;
        cmd_o.run_byte  = byte_q;
        byte_d          = in_item_i.data_byte;
        cnt_d           = 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'd0;
      cnt_q  <= 8'd0;
    end else begin
      byte_q <= byte_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pkb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// PackBits command queue
// Short first-in first-out queue of pack commands between collector and packer.
// ----------------------------------------------------------------------------
`default_nettype none

module pkb_cmd_fifo #(
  parameter int unsigned DEPTH = pkb_pkg::CMD_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire pkb_pkg::pkb_cmd_t data_i,
  output logic                   full_o,
  output logic                   valid_o,
  output pkb_pkg::pkb_cmd_t      data_o,
  input  wire logic              pop_i
);
  import pkb_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pkb_cmd_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Command pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(DEPTH))
    else $error("Command queue fill count out of range.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("Empty command queue with unequal pointers.");
`endif

endmodule

`default_nettype wire

// ===== rtl/pkb_back.sv =====
// ----------------------------------------------------------------------------
// PackBits packer
// Turns pack commands into addressed byte writes, one write per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pkb_back #(
  parameter int unsigned ADDR_BITS = pkb_pkg::ADDR_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire pkb_pkg::pkb_cmd_t cmd_i,
  output logic                   cmd_pop_o,
  output logic                   empty_o,
  output pkb_pkg::pkb_out_t      out_data_o,
  input  wire logic              pop_i
);
  import pkb_pkg::*;

  localparam int unsigned AW = ADDR_BITS;

  localparam logic [2:0] K_MARK   = 3'd0;
  localparam logic [2:0] K_REPEAT = 3'd1;
  localparam logic [2:0] K_START  = 3'd2;
  localparam logic [2:0] K_EXTEND = 3'd3;
  localparam logic [2:0] K_MERGE  = 3'd4;

  logic [1:0]    phase_q, phase_d;
  logic [AW-1:0] hdr_q, hdr_d;
  logic [6:0]    lcm_q, lcm_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          pair_q, pair_d;
  logic [7:0]    lrb_q, lrb_d;
  logic          sub_q, sub_d;
  pkb_out_t      out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          out_ready, emit, merge, last_step;
  logic [1:0]    eff_phase;
  logic [2:0]    kind;
  logic [AW-1:0] pos_p1, pos_p2, pos_m2;
  logic [6:0]    lcm_p1, lcm_p2;
  logic          w_valid;
  logic [AW-1:0] w_addr, w_len;
  logic [7:0]    w_data;
  logic [31:0]   addr_ext, len_ext;

  assign out_ready = !out_valid_q || pop_i;
  assign emit      = cmd_valid_i && out_ready;
  assign pos_p1    = pos_q + AW'(1);
  assign pos_p2    = pos_q + AW'(2);
  assign pos_m2    = pos_q - AW'(2);
  assign lcm_p1    = lcm_q + 7'd1;
  assign lcm_p2    = lcm_q + 7'd2;

  assign merge = (phase_q == PH_LITRUN) && (cmd_i.run_len == 8'd1) && pair_q &&
                 (lcm_q <= MERGE_LIMIT);
  assign eff_phase = ((phase_q == PH_LITRUN) && !merge) ? PH_RUN : phase_q;

  always_comb begin
    if (!cmd_i.has_chunk) begin
      kind = K_MARK;
    end else if (merge) begin
      kind = K_MERGE;
    end else if (cmd_i.run_len != 8'd1) begin
      kind = K_REPEAT;
    end else if (eff_phase == PH_LITERAL) begin
      kind = K_EXTEND;
    end else begin
      kind = K_START;
    end
  end

  assign last_step = (kind == K_MARK) || (sub_q && (kind != K_MERGE));
  assign cmd_pop_o = emit && last_step;

  always_comb begin
    w_valid = 1'b1;
    w_addr  = pos_q;
    w_data  = 8'd0;
    w_len   = pos_p1;
    case (kind)
      K_REPEAT: begin
        if (!sub_q) begin
          w_data = 8'd1 - cmd_i.run_len;
        end else begin
          w_addr = pos_p1;
          w_data = cmd_i.run_byte;
          w_len  = pos_p2;
        end
      end
      K_START: begin
        if (sub_q) begin
          w_addr = pos_p1;
          w_data = cmd_i.run_byte;
          w_len  = pos_p2;
        end
      end
      K_EXTEND: begin
        if (!sub_q) begin
          w_data = cmd_i.run_byte;
        end else begin
          w_addr = hdr_q;
          w_data = {1'b0, lcm_p1};
        end
      end
      K_MERGE: begin
        w_len = pos_q;
        if (!sub_q) begin
          w_addr = hdr_q;
          w_data = {1'b0, lcm_p2};
        end else begin
          w_addr = pos_m2;
          w_data = lrb_q;
        end
      end
      default: begin
        w_valid = 1'b0;
        w_addr  = '0;
        w_len   = pos_q;
      end
    endcase
  end

  assign addr_ext = 32'(w_addr);
  assign len_ext  = 32'(w_len);

  always_comb begin
    out_d               = out_q;
    out_valid_d         = out_valid_q;
    if (emit) begin
      out_d.write_valid   = w_valid;
      out_d.write_addr    = addr_ext[15:0];
      out_d.write_data    = w_data;
      out_d.stream_done   = last_step && cmd_i.is_end;
      out_d.output_length = len_ext[15:0];
      out_d.last_of_item  = last_step;
      out_valid_d         = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    lcm_d   = lcm_q;
    pos_d   = pos_q;
    pair_d  = pair_q;
    lrb_d   = lrb_q;
    sub_d   = sub_q;
    if (emit) begin
      sub_d = !sub_q && (kind != K_MARK);
      if (sub_q) begin
        case (kind)
          K_REPEAT: begin
            pos_d   = pos_p2;
            pair_d  = (cmd_i.run_len == 8'd2);
            lrb_d   = cmd_i.run_byte;
            phase_d = (eff_phase == PH_LITERAL) ? PH_LITRUN : PH_RUN;
          end
          K_START: begin
            hdr_d   = pos_q;
            lcm_d   = 7'd0;
            pos_d   = pos_p2;
            phase_d = PH_LITERAL;
          end
          K_EXTEND: begin
            lcm_d   = lcm_p1;
            pos_d   = pos_p1;
            phase_d = (lcm_p1 == LIT_LAST) ? PH_INITIAL : PH_LITERAL;
          end
          K_MERGE: begin
            lcm_d   = lcm_p2;
            phase_d = (lcm_p2 == LIT_LAST) ? PH_INITIAL : PH_LITERAL;
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
      if (last_step && cmd_i.is_end) begin
        phase_d = PH_INITIAL;
        hdr_d   = '0;
        lcm_d   = 7'd0;
        pos_d   = '0;
        pair_d  = 1'b0;
        lrb_d   = 8'd0;
        sub_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_INITIAL;
      hdr_q       <= '0;
      lcm_q       <= 7'd0;
      pos_q       <= '0;
      pair_q      <= 1'b0;
      lrb_q       <= 8'd0;
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_q       <= hdr_d;
      lcm_q       <= lcm_d;
      pos_q       <= pos_d;
      pair_q      <= pair_d;
      lrb_q       <= lrb_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (phase_q == PH_LITERAL) |-> (lcm_q != LIT_LAST))
    else $error("Open literal already holds the maximum count.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (emit && sub_q && (kind == K_MERGE)) |=> (cmd_valid_i && !sub_q))
    else $error("Merged pair was not followed by its literal step.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_q.stream_done) |-> out_q.last_of_item)
    else $error("End of stream not on the last write of a transaction.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (emit && last_step && cmd_i.is_end) |=>
                   ((pos_q == '0) && (phase_q == PH_INITIAL)))
    else $error("Packer state not cleared after end of stream.");
`endif

endmodule

`default_nettype wire

// ===== rtl/packbits_compressor.sv =====
// ----------------------------------------------------------------------------
// PackBits compressor
// Byte stream in, PackBits output out as addressed byte writes.
// ----------------------------------------------------------------------------
// Input transactions carry one data byte or an end-of-stream mark; they are
// taken when push is high and full is low. Result transactions are byte
// writes (address, data, running length) and are taken when pop is high and
// empty is low. A literal's count byte is rewritten at its header address
// each time the literal grows, so the receiver must honour every address.
// An end item flushes the pending run, tags its last write with stream_done
// and restarts addressing at zero; with nothing pending it yields one empty
// marker transaction. Every input that yields results has last_of_item set
// on its final write. An item's writes pass the command queue and the output
// register. The collector takes one item per cycle while full is low; the
// packer issues one write per cycle unless the receiver stalls, two for a
// finished run or single byte and four when a pair is folded into a literal.
// Bytes that only lengthen a run produce nothing. The command queue absorbs
// bursts and a stalled receiver holds the output register; full rises once
// the queue is full. Reset clears all run, literal and address state.
// ----------------------------------------------------------------------------
`default_nettype none

module packbits_compressor #(
  parameter int unsigned ADDR_BITS = pkb_pkg::ADDR_BITS_DEF,
  parameter int unsigned CMD_DEPTH = pkb_pkg::CMD_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  input  wire pkb_pkg::pkb_in_t in_data_i,
  output logic                  full,
  output logic                  empty,
  output pkb_pkg::pkb_out_t     out_data_o,
  input  wire logic             pop
);
  import pkb_pkg::*;

  logic     in_accept;
  logic     cmd_push, cmd_valid, cmd_pop;
  pkb_cmd_t cmd_in, cmd_head;

  assign in_accept = push && !full;

  pkb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_item_i   (in_data_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  pkb_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .valid_o (cmd_valid),
    .data_o  (cmd_head),
    .pop_i   (cmd_pop)
  );

  pkb_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .out_data_o  (out_data_o),
    .pop_i       (pop)
  );

endmodule

`default_nettype wire

// ===== tb/packbits_compressor_tb.sv =====
// ----------------------------------------------------------------------------
// PackBits compressor testbench
// Drives byte streams into the compressor through its push/full side and
// checks every write transaction popped from its empty/pop side against a
// behavioural prediction of the PackBits packer, under varied idling and
// back-pressure, including a run longer than one chunk and folded pairs.
// ----------------------------------------------------------------------------
module packbits_compressor_tb;
  import pkb_pkg::*;

  localparam int unsigned AW          = 16;
  localparam int          CYCLE_LIMIT = 20000;
  localparam int          DRAIN_TAIL  = 20;

  typedef logic [AW-1:0] addr_t;

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     push      = 1'b0;
  pkb_in_t  in_data_i = '0;
  logic     pop       = 1'b0;
  logic     full;
  logic     empty;
  pkb_out_t out_data_o;

  packbits_compressor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_data_i  (in_data_i),
    .full       (full),
    .empty      (empty),
    .out_data_o (out_data_o),
    .pop        (pop)
  );

  // Prediction state of the collector and the packer.
  logic [1:0] m_phase;
  addr_t      m_lit_hdr;
  logic [6:0] m_lit_cnt;
  addr_t      m_wpos;
  logic       m_pair;
  logic [7:0] m_pair_byte;
  logic [7:0] m_pend_byte;
  logic [7:0] m_pend_cnt;

  pkb_out_t item_writes[$];
  pkb_out_t exp_writes[$];

  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_request   = 0;
  int         hold_left      = 0;
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  logic [7:0] prev_data      = 8'h00;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_model();
    m_phase     = PH_INITIAL;
    m_lit_hdr   = '0;
    m_lit_cnt   = '0;
    m_wpos      = '0;
    m_pair      = 1'b0;
    m_pair_byte = '0;
    m_pend_byte = '0;
    m_pend_cnt  = '0;
  endfunction

  function automatic void add_write(addr_t addr, logic [7:0] data, bit advance);
    pkb_out_t w;
    if (advance) begin
      m_wpos = m_wpos + 1'b1;
    end
    w               = '0;
    w.write_valid   = 1'b1;
    w.write_addr    = addr;
    w.write_data    = data;
    w.output_length = m_wpos;
    item_writes.push_back(w);
  endfunction

  function automatic void emit_repeat(logic [7:0] n, logic [7:0] b);
    add_write(m_wpos, 8'd1 - n, 1'b1);
    add_write(m_wpos, b, 1'b1);
    m_pair      = (n == 8'd2);
    m_pair_byte = b;
  endfunction

  function automatic void start_literal(logic [7:0] b);
    m_lit_hdr = m_wpos;
    m_lit_cnt = '0;
    add_write(m_wpos, 8'h00, 1'b1);
    add_write(m_wpos, b, 1'b1);
    m_phase = PH_LITERAL;
  endfunction

  function automatic void pack_run(logic [7:0] n, logic [7:0] b);
    bit again;
    do begin
      again = 1'b0;
      case (m_phase)
        PH_INITIAL: begin
          if (n > 8'd1) begin
            emit_repeat(n, b);
            m_phase = PH_RUN;
          end else begin
            start_literal(b);
          end
        end
        PH_LITERAL: begin
          if (n > 8'd1) begin
            emit_repeat(n, b);
            m_phase = PH_LITRUN;
          end else begin
            add_write(m_wpos, b, 1'b1);
            m_lit_cnt = m_lit_cnt + 1'b1;
            add_write(m_lit_hdr, {1'b0, m_lit_cnt}, 1'b0);
            if (m_lit_cnt == LIT_LAST) begin
              m_phase = PH_INITIAL;
            end
          end
        end
        PH_RUN: begin
          if (n > 8'd1) begin
            emit_repeat(n, b);
          end else begin
            start_literal(b);
          end
        end
        default: begin
          if (n == 8'd1 && m_pair && m_lit_cnt <= MERGE_LIMIT) begin
            m_lit_cnt = m_lit_cnt + 7'd2;
            m_phase   = (m_lit_cnt == LIT_LAST) ? PH_INITIAL : PH_LITERAL;
            add_write(m_lit_hdr, {1'b0, m_lit_cnt}, 1'b0);
            add_write(addr_t'(m_wpos - addr_t'(2)), m_pair_byte, 1'b0);
          end else begin
            m_phase = PH_RUN;
          end
          again = 1'b1;
        end
      endcase
    end while (again);
  endfunction

  function automatic void compress_item(pkb_in_t it);
    pkb_out_t w;
    item_writes.delete();
    if (it.action == ACT_DATA) begin
      if (m_pend_cnt == 8'd0) begin
        m_pend_byte = it.data_byte;
        m_pend_cnt  = 8'd1;
      end else if (it.data_byte == m_pend_byte) begin
        if (m_pend_cnt < CHUNK_MAX) begin
          m_pend_cnt = m_pend_cnt + 1'b1;
        end else begin
          pack_run(CHUNK_MAX, m_pend_byte);
          m_pend_cnt = 8'd1;
        end
      end else begin
        pack_run(m_pend_cnt, m_pend_byte);
        m_pend_byte = it.data_byte;
        m_pend_cnt  = 8'd1;
      end
    end else begin
      if (m_pend_cnt != 8'd0) begin
        pack_run(m_pend_cnt, m_pend_byte);
      end
      if (item_writes.size() == 0) begin
        w               = '0;
        w.output_length = m_wpos;
        item_writes.push_back(w);
      end
      w             = item_writes.pop_back();
      w.stream_done = 1'b1;
      item_writes.push_back(w);
      clear_model();
    end
    if (item_writes.size() != 0) begin
      w              = item_writes.pop_back();
      w.last_of_item = 1'b1;
      item_writes.push_back(w);
    end
    foreach (item_writes[i]) begin
      exp_writes.push_back(item_writes[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_writes
    pkb_out_t want;
    if (rst_ni && pop && !empty) begin
      if (exp_writes.size() == 0) begin
        mismatch_count++;
        $display("%0t: write expected none, got %p", $time, out_data_o);
      end else begin
        want = exp_writes.pop_front();
        check_field("write_valid", 16'(want.write_valid), 16'(out_data_o.write_valid));
        check_field("write_addr", want.write_addr, out_data_o.write_addr);
        check_field("write_data", 16'(want.write_data), 16'(out_data_o.write_data));
        check_field("stream_done", 16'(want.stream_done), 16'(out_data_o.stream_done));
        check_field("output_length", want.output_length, out_data_o.output_length);
        check_field("last_of_item", 16'(want.last_of_item),
                    16'(out_data_o.last_of_item));
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Returns at the accepting edge with push still high; the next call or
  // stop_sending decides push at the following falling edge.
  task automatic send_item(input pkb_in_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    compress_item(it);
  endtask

  task automatic send_data(input logic [7:0] b);
    pkb_in_t it;
    it.action    = ACT_DATA;
    it.data_byte = b;
    prev_data    = b;
    send_item(it);
  endtask

  task automatic send_end();
    pkb_in_t it;
    it.action    = ACT_END;
    it.data_byte = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_run(input int n, input logic [7:0] b);
    repeat (n) send_data(b);
  endtask

  task automatic send_literal(input int n);
    repeat (n) send_data(prev_data + 8'($urandom_range(1, 255)));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  task automatic wait_for_writes();
    stop_sending();
    while (exp_writes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic test_basic_cases();
    send_end();
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h00);
    send_end();
    send_run(3, 8'hFF);
    send_end();
    send_data(8'h11);
    send_run(2, 8'h22);
    send_data(8'h33);
    send_end();
    send_run(2, 8'h44);
    send_run(2, 8'h55);
    send_data(8'h66);
    send_end();
    send_data(8'h77);
    send_run(3, 8'h88);
    send_data(8'h99);
    send_end();
    wait_for_writes();
  endtask

  task automatic test_long_runs();
    send_run(129, 8'hA5);
    send_end();
    wait_for_writes();
  endtask

  task automatic test_receiver_hold();
    hold_request = 100;
    send_literal(10);
    send_end();
    wait_for_writes();
  endtask

  task automatic send_random_streams(input int n_items);
    int         sent;
    int         len;
    int         pick;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          len = 1;
        end else if (pick < 70) begin
          len = 2;
        end else if (pick < 95) begin
          len = $urandom_range(3, 5);
        end else begin
          len = $urandom_range(6, 9);
        end
        b = ($urandom_range(0, 9) == 0) ? prev_data : prev_data + 8'($urandom_range(1, 255));
        send_run(len, b);
        sent += len;
      end
      send_end();
      sent++;
      if ($urandom_range(0, 7) == 0) begin
        send_end();
        sent++;
      end
    end
  endtask

  task automatic test_random_streams();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_streams(6);
    wait_for_writes();
    send_idle_pct  = 58;
    send_random_streams(6);
    wait_for_writes();
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    send_random_streams(6);
    wait_for_writes();
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    send_random_streams(6);
    wait_for_writes();
  endtask

  initial begin
    clear_model();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_cases();
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    test_long_runs();
    test_receiver_hold();
    test_random_streams();
    if (mismatch_count == 0 && exp_writes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
